// ===== hdl/lrl_pkg.sv =====
// ----------------------------------------------------------------------------
// lrl_pkg
// Shared types and constants for the LRU recency list core.
// ----------------------------------------------------------------------------
package lrl_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 16;

  // Fixed widths of the channel fields
  localparam int IO_KEY_W = 16;
  localparam int CAP_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } lrl_state_t;

  typedef struct packed {
    logic load_key;
    logic compare;
    logic update;
  } lrl_cmd_t;

endpackage

// ===== hdl/lru_recency_list_core.sv =====
// ----------------------------------------------------------------------------
// lru_recency_list_core
// LRU recency list with move-to-front and eviction at a set capacity.
// ----------------------------------------------------------------------------
// Each item on the input channel (in_valid / in_stall) carries one key. The
// result channel (out_valid / out_stall) returns one item per access: hit,
// whether a key was evicted, the evicted key (zero when none) and the number
// of keys held afterwards. A hit moves the key to the front; a miss inserts
// it at the front, evicting the back key once the list holds capacity keys.
// cfg_wr_en / cfg_wr_data write the capacity; write it only while idle.
// Zero acts as one, values above ENTRIES act as ENTRIES.
// Each access runs in order: capture at the accept edge, parallel compare over
// all entries, then shift update into the output register. The sequencer takes
// one access at a time, so no item is accepted until the last one has updated.
// A result waits in the output register while out_stall is high; the next
// item is still accepted and completes its compare, then holds in the update
// step until the output register is free.
// Reset clears the held count to zero and the capacity to 16; the key list
// needs no clearing since only held entries are compared.
// ----------------------------------------------------------------------------
module lru_recency_list_core #(
  parameter int ENTRIES  = lrl_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lrl_pkg::KEY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lrl_pkg::IO_KEY_W-1:0] in_access_key,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic                         out_evicted_valid,
  output logic [lrl_pkg::IO_KEY_W-1:0] out_evicted_key,
  output logic [lrl_pkg::CAP_W-1:0]    out_occupancy,
  input  logic                         cfg_wr_en,
  input  logic [lrl_pkg::CAP_W-1:0]    cfg_wr_data
);
  import lrl_pkg::*;

  lrl_cmd_t cmd;

  lrl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lrl_datapath #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_key            (in_access_key),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_hit           (out_hit),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_key   (out_evicted_key),
    .out_occupancy     (out_occupancy)
  );

endmodule

// ===== hdl/lrl_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrl_ctrl
// Sequencer for one access: capture, compare, update; owns the handshakes.
// ----------------------------------------------------------------------------
module lrl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output lrl_pkg::lrl_cmd_t cmd
);
  import lrl_pkg::*;

  lrl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        // hold until the output register can take the result
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    cmd.load_key = 1'b0;
    cmd.compare  = 1'b0;
    cmd.update   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall     = 1'b0;
        cmd.load_key = in_valid;
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
      end
      ST_UPD: begin
        cmd.update = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hdl/lrl_datapath.sv =====
// ----------------------------------------------------------------------------
// lrl_datapath
// Key shift list, parallel match, eviction pick and result register.
// ----------------------------------------------------------------------------
module lrl_datapath #(
  parameter int ENTRIES  = lrl_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lrl_pkg::KEY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lrl_pkg::lrl_cmd_t            cmd,
  input  logic [lrl_pkg::IO_KEY_W-1:0] in_key,
  input  logic                         cfg_wr_en,
  input  logic [lrl_pkg::CAP_W-1:0]    cfg_wr_data,
  output logic                         out_hit,
  output logic                         out_evicted_valid,
  output logic [lrl_pkg::IO_KEY_W-1:0] out_evicted_key,
  output logic [lrl_pkg::CAP_W-1:0]    out_occupancy
);
  import lrl_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);

  logic [KEY_BITS-1:0] keys_r [ENTRIES];
  logic [KEY_BITS-1:0] key_r;
  logic [CAP_W-1:0]    held_r;
  logic [CAP_W-1:0]    cap_r;

  // compare stage results
  logic                hit_r;
  logic                evict_r;
  logic [IDX_W-1:0]    upto_r;
  logic [CAP_W-1:0]    held_new_r;
  logic [KEY_BITS-1:0] ev_key_r;

  // output register
  logic                hit_out_r;
  logic                ev_out_r;
  logic [IO_KEY_W-1:0] ev_key_out_r;
  logic [CAP_W-1:0]    occ_out_r;

  logic [CAP_W-1:0]    eff_cap;
  logic [ENTRIES-1:0]  match;
  logic                hit_w;
  logic [IDX_W-1:0]    pos_w;
  logic [IDX_W-1:0]    last_idx;
  logic                full_w;
  logic [IDX_W-1:0]    upto_w;
  logic [CAP_W-1:0]    held_new_w;

  always_comb begin
    eff_cap = (cap_r == '0) ? CAP_W'(1) : cap_r;
    if (int'(eff_cap) > ENTRIES) eff_cap = CAP_W'(ENTRIES);
  end

  // only entries below the held count take part
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = (keys_r[i] == key_r) && (i < int'(held_r));
    end
  end

  always_comb begin
    pos_w = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) pos_w = IDX_W'(i);
    end
  end

  assign hit_w    = |match;
  assign last_idx = IDX_W'(held_r - CAP_W'(1));
  assign full_w   = (held_r >= eff_cap);

  always_comb begin
    if (hit_w) begin
      upto_w     = pos_w;
      held_new_w = held_r;
    end else if (full_w) begin
      if (held_r != '0) begin
        upto_w     = last_idx;
        held_new_w = held_r;
      end else begin
        upto_w     = '0;
        held_new_w = CAP_W'(1);
      end
    end else begin
      upto_w     = IDX_W'(held_r);
      held_new_w = held_r + CAP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      cap_r  <= CAP_RESET;
    end else begin
      if (cfg_wr_en) cap_r <= cfg_wr_data;
      if (cmd.update) held_r <= held_new_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) key_r <= KEY_BITS'(in_key);
    if (cmd.compare) begin
      hit_r      <= hit_w;
      evict_r    <= !hit_w && full_w && (held_r != '0);
      upto_r     <= upto_w;
      held_new_r <= held_new_w;
      ev_key_r   <= keys_r[last_idx];
    end
    if (cmd.update) begin
      // advance entries up to the vacated slot, new key at the front
      for (int i = 0; i < ENTRIES; i++) begin
        if (i == 0) begin
          keys_r[i] <= key_r;
        end else if (i <= int'(upto_r)) begin
          keys_r[i] <= keys_r[i-1];
        end
      end
      hit_out_r    <= hit_r;
      ev_out_r     <= evict_r;
      ev_key_out_r <= evict_r ? IO_KEY_W'(ev_key_r) : '0;
      occ_out_r    <= held_new_r;
    end
  end

  assign out_hit           = hit_out_r;
  assign out_evicted_valid = ev_out_r;
  assign out_evicted_key   = ev_key_out_r;
  assign out_occupancy     = occ_out_r;

endmodule

// ===== tb/lru_recency_list_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_recency_list_core_test
// Self-checking bench for the LRU recency list core. A queue-fed driver
// offers keys and a clocked monitor checks every result against an in-bench
// recency list under several capacity settings and idle patterns.
// ----------------------------------------------------------------------------
module lru_recency_list_core_test;
  import lrl_pkg::*;

  localparam int ENTRIES     = ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 20;
  localparam int PHASE_ITEMS = 67;

  typedef struct packed {
    logic                evicted_valid;
    logic                hit;
    logic [IO_KEY_W-1:0] evicted_key;
    logic [CAP_W-1:0]    occupancy;
  } access_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [IO_KEY_W-1:0] in_access_key = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_hit;
  logic                out_evicted_valid;
  logic [IO_KEY_W-1:0] out_evicted_key;
  logic [CAP_W-1:0]    out_occupancy;
  logic                cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]    cfg_wr_data = '0;

  // Predicted recency list, front at index 0
  logic [IO_KEY_W-1:0] recency_list [ENTRIES];
  int                  keys_held;
  logic [CAP_W-1:0]    capacity_setting;

  logic [IO_KEY_W-1:0] pending_keys [$];
  access_result_t      expected_results [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned keys_queued;
  int unsigned keys_accepted;
  int unsigned results_checked;
  int unsigned hits_seen;
  int unsigned evictions_seen;
  int unsigned settings_used;
  int unsigned fail_count;
  int unsigned cycle_count;

  lru_recency_list_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_access_key     (in_access_key),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_key   (out_evicted_key),
    .out_occupancy     (out_occupancy),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int effective_capacity();
    if (capacity_setting == '0) return 1;
    if (capacity_setting > ENTRIES) return ENTRIES;
    return int'(capacity_setting);
  endfunction

  // Shift entries [0, upto) one place back and put key at the front.
  function automatic void move_to_front(input int upto, input logic [IO_KEY_W-1:0] key);
    int i;
    for (i = upto; i > 0; i--) recency_list[i] = recency_list[i-1];
    recency_list[0] = key;
  endfunction

  function automatic access_result_t lookup_and_update(input logic [IO_KEY_W-1:0] key);
    access_result_t res;
    int pos;
    int i;
    res = '0;
    pos = -1;
    for (i = 0; i < keys_held; i++) begin
      if (pos < 0 && recency_list[i] == key) pos = i;
    end
    if (pos >= 0) begin
      res.hit = 1'b1;
      move_to_front(pos, key);
    end else if (keys_held >= effective_capacity()) begin
      // full (or over a lowered capacity): drop the back key, size unchanged
      res.evicted_valid = 1'b1;
      res.evicted_key   = recency_list[keys_held-1];
      move_to_front(keys_held - 1, key);
    end else begin
      move_to_front(keys_held, key);
      keys_held++;
    end
    res.occupancy = CAP_W'(keys_held);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("lru_recency_list_core_test NOT OK");
      $finish;
    end
  end

  // Driver: hold an offered item until accepted, then maybe idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.insert(expected_results.size(), lookup_and_update(in_access_key));
        keys_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_keys.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid      <= 1'b1;
          in_access_key <= pending_keys[0];
          pending_keys.delete(0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted item against the oldest prediction.
  always @(posedge clk) begin
    access_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          report_mismatch("result item with no access pending");
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (out_hit !== want.hit)
            report_mismatch($sformatf("hit %b, want %b", out_hit, want.hit));
          if (out_evicted_valid !== want.evicted_valid)
            report_mismatch($sformatf("evicted_valid %b, want %b",
                                      out_evicted_valid, want.evicted_valid));
          if (out_evicted_key !== want.evicted_key)
            report_mismatch($sformatf("evicted_key %h, want %h",
                                      out_evicted_key, want.evicted_key));
          if (out_occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy %0d, want %0d",
                                      out_occupancy, want.occupancy));
          hits_seen      += want.hit;
          evictions_seen += want.evicted_valid;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic queue_key(input logic [IO_KEY_W-1:0] key);
    pending_keys.insert(pending_keys.size(), key);
    keys_queued++;
  endtask

  task automatic wait_idle();
    while (keys_accepted != keys_queued || expected_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    capacity_setting = value;
    settings_used++;
  endtask

  task automatic set_idle_mode(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 29;
        recv_idle_pct = 83;
      end
      1: begin
        send_idle_pct = 83;
        recv_idle_pct = 29;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  initial begin
    logic [CAP_W-1:0]    phase_caps [9];
    logic [IO_KEY_W-1:0] key_pool [24];
    int pool_size;
    int ph;
    int n;

    keys_held        = 0;
    capacity_setting = CAP_RESET;
    phase_caps = '{5'd17, 5'd1, 5'd5, 5'd16, 5'd3, 5'd12, 5'd0, 5'd31, 5'd8};
    set_idle_mode(0);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes of the key, hits at front and back, misses
    queue_key(16'h0000);
    queue_key(16'hFFFF);
    queue_key(16'h0000);
    queue_key(16'h0000);
    queue_key(16'h5A5A);
    queue_key(16'hA5A5);
    // capacity lowered below occupancy: hits keep size, misses evict
    write_capacity(5'd2);
    queue_key(16'hFFFF);
    queue_key(16'h1234);
    // zero acts as one
    write_capacity(5'd0);
    queue_key(16'h8001);
    queue_key(16'h8001);
    // above the entry count saturates: grow to full, then evict once
    write_capacity(5'd31);
    for (n = 0; n < 13; n++) queue_key(IO_KEY_W'(1) << n);

    for (ph = 0; ph < 9; ph++) begin
      write_capacity(phase_caps[ph]);
      set_idle_mode(ph / 3);
      // a pool a bit larger than the capacity gives a mix of hits and evictions
      pool_size = effective_capacity() + 1 + $urandom_range(6);
      for (n = 0; n < pool_size; n++) key_pool[n] = IO_KEY_W'($urandom_range(65535));
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 85)
          queue_key(key_pool[$urandom_range(pool_size - 1)]);
        else
          queue_key(IO_KEY_W'($urandom_range(65535)));
      end
    end

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("Run covered %0d accesses (%0d hits, %0d evictions) over %0d capacity writes,",
             results_checked, hits_seen, evictions_seen, settings_used);
    $display("with sender-heavy, receiver-heavy and gap-free handshake phases.");
    if (fail_count == 0) begin
      $display("lru_recency_list_core_test OK");
    end else begin
      $display("lru_recency_list_core_test NOT OK");
    end
    $finish;
  end

endmodule
